/* rtl/core/clist_pkg.sv */
// shared types and constants for the cursor ordered list
package clist_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);

    localparam int KIND_W  = 3;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;
    localparam int ERR_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_START   = 3'd0,
        KIND_ADVANCE = 3'd1,
        KIND_INSERT  = 3'd2,
        KIND_ATTACH  = 3'd3,
        KIND_REMOVE  = 3'd4,
        KIND_READ    = 3'd5
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_FULL       = 2'd1,
        ERR_NO_CURRENT = 2'd2
    } t_err;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0]  current_value;
        logic               has_current;
        logic [COUNT_W-1:0] entry_count;
        logic [ERR_W-1:0]   error_code;
    } t_out_beat;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dp_cmd;

endpackage

/* rtl/core/clist_ctrl.sv */
// controller: sequences capture, execute and result load
module clist_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output clist_pkg::t_dp_cmd o_cmd
);
    import clist_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    // output register free or being emptied this cycle
    assign can_load    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_LOAD;
            end
            ST_LOAD: begin
                if (can_load) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/clist_dp.sv */
// datapath: shifting row of entry cells, count, cursor and result register
module clist_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  clist_pkg::t_dp_cmd   i_cmd,
    input  clist_pkg::t_in_beat  i_in_data,
    output clist_pkg::t_out_beat o_out_data
);
    import clist_pkg::*;

    logic [KIND_W-1:0]      r_kind;
    logic [VALUE_WIDTH-1:0] r_word;
    logic [ERR_W-1:0]       r_err, n_err;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0]       r_cur, n_cur;
    logic [VALUE_WIDTH-1:0] r_cell [CAPACITY];
    logic [VALUE_WIDTH-1:0] n_cell [CAPACITY];
    t_out_beat              r_out;

    logic             item, full, do_ins, do_rem;
    logic [CNT_W-1:0] ins_pos;

    assign item = (r_cur < r_cnt);
    assign full = (r_cnt == CNT_W'(CAPACITY));

    always_comb begin
        n_cur   = r_cur;
        n_cnt   = r_cnt;
        n_err   = ERR_OK;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        ins_pos = '0;
        unique case (r_kind)
            KIND_START: begin
                n_cur = '0;
            end
            KIND_ADVANCE: begin
                if (item) begin
                    n_cur = r_cur + CNT_W'(1);
                end
            end
            KIND_INSERT: begin
                if (full) begin
                    n_err = ERR_FULL;
                end else begin
                    do_ins  = 1'b1;
                    ins_pos = item ? r_cur : '0;
                    n_cur   = ins_pos;
                    n_cnt   = r_cnt + CNT_W'(1);
                end
            end
            KIND_ATTACH: begin
                if (full) begin
                    n_err = ERR_FULL;
                end else begin
                    do_ins  = 1'b1;
                    ins_pos = item ? (r_cur + CNT_W'(1)) : r_cnt;
                    n_cur   = ins_pos;
                    n_cnt   = r_cnt + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                if (!item) begin
                    n_err = ERR_NO_CURRENT;
                end else begin
                    do_rem = 1'b1;
                    n_cnt  = r_cnt - CNT_W'(1);
                end
            end
            default: ;  // read and unused kinds leave the list alone
        endcase
    end

    // each cell looks only at its neighbors
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        always_comb begin
            n_cell[gi] = r_cell[gi];
            if (do_ins) begin
                if (CNT_W'(gi) == ins_pos) begin
                    n_cell[gi] = r_word;
                end else if (CNT_W'(gi) > ins_pos) begin
                    if (gi > 0) begin
                        n_cell[gi] = r_cell[(gi > 0) ? gi - 1 : 0];
                    end
                end
            end else if (do_rem && (CNT_W'(gi) >= r_cur)) begin
                if (gi < CAPACITY - 1) begin
                    n_cell[gi] = r_cell[(gi < CAPACITY - 1) ? gi + 1 : gi];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                r_cell[gi] <= n_cell[gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_in_data.kind;
            r_word <= VALUE_WIDTH'(i_in_data.value);
        end
        if (i_cmd.exec) begin
            r_err <= n_err;
        end
        if (i_cmd.load) begin
            r_out.current_value <= item ? WORD_W'(r_cell[r_cur[IDX_W-1:0]]) : '0;
            r_out.has_current   <= item;
            r_out.entry_count   <= COUNT_W'(r_cnt);
            r_out.error_code    <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_cur <= '0;
        end else if (i_cmd.exec) begin
            r_cnt <= n_cnt;
            r_cur <= n_cur;
        end
    end

    assign o_out_data = r_out;

endmodule

/* rtl/core/cursor_ordered_list_top.sv */
// top level of the cursor ordered list
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (kind, value)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (current_value,
//          |           |                          |  has_current, entry_count,
//          |           |                          |  error_code)
//
// each beat passes in order through capture, execute on the cell row and result load
// the result load waits while the output register holds an untaken beat
// a new beat is taken as soon as the previous one is loaded, even if unread
// synchronous active-low reset empties the list and puts the cursor at 0
// entry cells are not reset; only entries below the count are ever read
module cursor_ordered_list_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  clist_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output clist_pkg::t_out_beat o_out_data
);
    import clist_pkg::*;

    // commands from controller to datapath
    t_dp_cmd cmd;

    // controller: one-hot state machine plus output valid flag
    clist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // datapath: cell row shifts every entry past the position at once, in the execute state
    clist_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

/* rtl/core/clist_chk.sv */
// port-level checker for the cursor ordered list, bound to the top level
module clist_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input clist_pkg::t_in_beat  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input clist_pkg::t_out_beat o_out_data
);
    import clist_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // no current entry means a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_current |-> o_out_data.current_value == '0)
        else $error("value shown without current entry");

    // count never exceeds capacity, and a current entry needs a nonempty list
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.entry_count <= COUNT_W'(CAPACITY)
            && (!o_out_data.has_current || o_out_data.entry_count != '0))
        else $error("count out of range");

    // full error only when the list is full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_code == ERR_FULL
            |-> o_out_data.entry_count == COUNT_W'(CAPACITY))
        else $error("full error on a list with room");

    // remove error only without a current entry
    a_no_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_code == ERR_NO_CURRENT
            |-> !o_out_data.has_current)
        else $error("remove error with a current entry");

endmodule

bind cursor_ordered_list_top clist_chk u_chk (.*);

/* verif/cursor_ordered_list_top_tb.sv */
// testbench for the cursor ordered list: directed table, then biased random operations
`timescale 1ns / 1ps

module cursor_ordered_list_top_tb;
    import clist_pkg::*;

    // kinds outside the package enum, which the block treats as a read
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int RAND_OPS  = 690;
    localparam int CALM_TAIL = 120;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    cursor_ordered_list_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // one row of the directed table; reps repeats the row with value + index
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] value;
        int                reps;
        bit                pinned;
        t_out_beat         result;
    } t_list_step;

    // shadow copy of the list kept by the predictor
    logic [WORD_W-1:0] shadow_words [CAPACITY];
    int                shadow_len = 0;
    int                shadow_cursor = 0;

    t_out_beat   list_results_due [$];
    t_list_step  directed_steps [$];
    int          fail_count = 0;
    bit          calm = 0;

    // result a typed-in row expects, handed to the monitor along with the beat
    bit          op_pinned = 0;
    t_out_beat   op_pinned_res = '0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // applies one operation to the shadow list and returns the state afterwards
    function automatic t_out_beat list_apply(t_in_beat op);
        t_out_beat res;
        t_err      err;
        bit        present;
        int        i;
        err = ERR_OK;
        present = shadow_cursor < shadow_len;
        case (op.kind)
            KIND_START: begin
                shadow_cursor = 0;
            end
            KIND_ADVANCE: begin
                if (present) shadow_cursor++;
            end
            KIND_INSERT, KIND_ATTACH: begin
                if (shadow_len >= CAPACITY) begin
                    err = ERR_FULL;
                end else begin
                    // insert with no current entry goes to the front;
                    // attach with no current entry lands at the end, where the cursor already is
                    if (op.kind == KIND_INSERT && !present) shadow_cursor = 0;
                    else if (op.kind == KIND_ATTACH && present) shadow_cursor++;
                    for (i = shadow_len; i > shadow_cursor; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[shadow_cursor] = op.value;
                    shadow_len++;
                end
            end
            KIND_REMOVE: begin
                if (!present) begin
                    err = ERR_NO_CURRENT;
                end else begin
                    for (i = shadow_cursor; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            default: ;
        endcase
        present = shadow_cursor < shadow_len;
        res.current_value = present ? shadow_words[shadow_cursor] : '0;
        res.has_current   = present;
        res.entry_count   = COUNT_W'(shadow_len);
        res.error_code    = err;
        return res;
    endfunction

    task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // monitor: checks result beats first, then predicts for an accepted op beat
    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat model_res;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (list_results_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, o_out_data);
                    fail_count++;
                end else begin
                    want = list_results_due.pop_front();
                    report_field("current_value", want.current_value,
                                 o_out_data.current_value);
                    report_field("has_current", WORD_W'(want.has_current),
                                 WORD_W'(o_out_data.has_current));
                    report_field("entry_count", WORD_W'(want.entry_count),
                                 WORD_W'(o_out_data.entry_count));
                    report_field("error_code", WORD_W'(want.error_code),
                                 WORD_W'(o_out_data.error_code));
                end
            end
            if (i_in_valid && o_in_ready) begin
                model_res = list_apply(i_in_data);
                list_results_due.push_back(op_pinned ? op_pinned_res : model_res);
            end
        end
    end

    // result side back-pressure: random stall bursts, none in the calm tail
    int stall_left = 0;
    initial i_out_ready = 1'b1;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else begin
            i_out_ready = 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
        end
    end

    // drives one op beat at the falling edge and holds it until taken
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
                           input bit pinned, input t_out_beat pinned_res);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_in_data.kind  = kind;
        i_in_data.value = word;
        op_pinned       = pinned;
        op_pinned_res   = pinned_res;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // sender goes quiet until every outstanding result has been checked
    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (list_results_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_step(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                            input int reps, input bit pinned, input logic [WORD_W-1:0] cv,
                            input logic hc, input logic [COUNT_W-1:0] cnt, input t_err err);
        t_list_step s;
        s.kind   = kind;
        s.value  = value;
        s.reps   = reps;
        s.pinned = pinned;
        s.result = {cv, hc, cnt, err};
        directed_steps.push_back(s);
    endtask

    // grow mode favors insert/attach to reach a full list, shrink mode favors remove
    function automatic logic [KIND_W-1:0] pick_kind(input bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return (r < 3) ? KIND_SPARE_LO : KIND_SPARE_HI;
        if (r < 10) return KIND_READ;
        if (growing) begin
            if (r < 40) return KIND_INSERT;
            if (r < 70) return KIND_ATTACH;
            if (r < 75) return KIND_REMOVE;
            if (r < 85) return KIND_START;
            return KIND_ADVANCE;
        end
        if (r < 15) return KIND_INSERT;
        if (r < 20) return KIND_ATTACH;
        if (r < 65) return KIND_REMOVE;
        if (r < 80) return KIND_START;
        return KIND_ADVANCE;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        #400000;
        $display("cursor_ordered_list_top_tb: errors");
        $finish;
    end

    initial begin
        bit growing;
        int r;
        int k;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        // directed table; rows with pinned = 1 carry their result typed in
        // empty list: reads, remove without current entry, advance going nowhere, spare kinds
        add_step(KIND_READ,     32'h0000_0000, 1,  1, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_REMOVE,   32'h0000_0000, 1,  1, 32'h0, 1'b0, 5'd0, ERR_NO_CURRENT);
        add_step(KIND_ADVANCE,  32'h0000_0000, 1,  1, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_SPARE_LO, 32'hFFFF_FFFF, 1,  1, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_SPARE_HI, 32'hFFFF_FFFF, 1,  1, 32'h0, 1'b0, 5'd0, ERR_OK);
        // extremes of the word, then walk off the end
        add_step(KIND_INSERT,   32'hFFFF_FFFF, 1,  1, 32'hFFFF_FFFF, 1'b1, 5'd1, ERR_OK);
        add_step(KIND_ATTACH,   32'h0000_0000, 1,  1, 32'h0, 1'b1, 5'd2, ERR_OK);
        add_step(KIND_START,    32'h0000_0000, 1,  1, 32'hFFFF_FFFF, 1'b1, 5'd2, ERR_OK);
        add_step(KIND_ADVANCE,  32'h0000_0000, 1,  1, 32'h0, 1'b1, 5'd2, ERR_OK);
        add_step(KIND_ADVANCE,  32'h0000_0000, 1,  1, 32'h0, 1'b0, 5'd2, ERR_OK);
        add_step(KIND_ADVANCE,  32'h0000_0000, 1,  1, 32'h0, 1'b0, 5'd2, ERR_OK);
        add_step(KIND_REMOVE,   32'h0000_0000, 1,  1, 32'h0, 1'b0, 5'd2, ERR_NO_CURRENT);
        // insert with no current entry goes to the front
        add_step(KIND_INSERT,   32'h5A5A_5A5A, 1,  0, 32'h0, 1'b0, 5'd0, ERR_OK);
        // fill to capacity, then both adds must report a full list
        add_step(KIND_ATTACH,   32'h0001_0000, 13, 0, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_INSERT,   32'h1234_5678, 1,  0, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_ATTACH,   32'h8765_4321, 1,  0, 32'h0, 1'b0, 5'd0, ERR_OK);
        // remove at the front, then walk to the last entry and remove it
        add_step(KIND_START,    32'h0000_0000, 1,  0, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_REMOVE,   32'h0000_0000, 1,  0, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_ADVANCE,  32'h0000_0000, 14, 0, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_REMOVE,   32'h0000_0000, 1,  0, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_REMOVE,   32'h0000_0000, 1,  0, 32'h0, 1'b0, 5'd0, ERR_OK);
        // empty it from the front
        add_step(KIND_START,    32'h0000_0000, 1,  0, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_REMOVE,   32'h0000_0000, 14, 0, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_READ,     32'h0000_0000, 1,  1, 32'h0, 1'b0, 5'd0, ERR_OK);
        add_step(KIND_ATTACH,   32'h8000_0001, 1,  1, 32'h8000_0001, 1'b1, 5'd1, ERR_OK);

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_steps[s]) begin
            for (r = 0; r < directed_steps[s].reps; r++)
                send_op(directed_steps[s].kind, directed_steps[s].value + r,
                        directed_steps[s].pinned, directed_steps[s].result);
        end

        // let the block drain completely once before the random part
        wait_for_results();

        growing = 1'b1;
        for (k = 0; k < RAND_OPS; k++) begin
            calm = (k >= RAND_OPS - CALM_TAIL);
            if ($urandom_range(0, 39) == 0) growing = !growing;
            send_op(pick_kind(growing), pick_word(), 1'b0, '0);
        end

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("cursor_ordered_list_top_tb: clean");
        end else begin
            $display("cursor_ordered_list_top_tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/clist_pkg.sv
rtl/core/clist_ctrl.sv
rtl/core/clist_dp.sv
rtl/core/cursor_ordered_list_top.sv
rtl/core/clist_chk.sv
verif/cursor_ordered_list_top_tb.sv
